/* hw/rtl/sbsi_pkg.sv */
// Shared types and codes for the sorted bitmap set intersect block.
`timescale 1ns / 1ps
package sbsi_pkg;

    localparam int BASE_W   = 31;
    localparam int STATE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_LIST_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LIST_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    typedef enum logic [1:0] {
        CMD_ELEM_A = 2'd0,
        CMD_ELEM_B = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [BASE_W-1:0]    base;
        logic [STATE_W-1:0]   state;
    } cmd_t;

endpackage

/* hw/rtl/sbsi_in_if.sv */
// Input item channel: action plus element base and state bitmap.
`timescale 1ns / 1ps
interface sbsi_in_if import sbsi_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BASE_W-1:0]   element_base;
    logic [STATE_W-1:0]  element_state;

    modport source (output valid, action, element_base, element_state, input ready);
    modport sink   (input valid, action, element_base, element_state, output ready);
endinterface

/* hw/rtl/sbsi_out_if.sv */
// Result item channel: match or finish report.
`timescale 1ns / 1ps
interface sbsi_out_if import sbsi_pkg::*;;
    logic               valid;
    logic               ready;
    logic               is_done;
    logic [BASE_W-1:0]  result_base;
    logic [STATE_W-1:0] result_state;
    logic [COUNT_W-1:0] match_count;
    logic               overflow_seen;

    modport source (output valid, is_done, result_base, result_state, match_count,
                    overflow_seen, input ready);
    modport sink   (input valid, is_done, result_base, result_state, match_count,
                    overflow_seen, output ready);
endinterface

/* hw/rtl/sbsi_front.sv */
// Front end: accepts input items, decodes the action and queues commands.
`timescale 1ns / 1ps
module sbsi_front import sbsi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sbsi_in_if.sink      items,
    output logic         cmd_valid,
    output cmd_t         cmd,
    input  logic         cmd_pop
);

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    cmd_t                cq_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    cmd_t                cmd_in;
    logic                push;
    logic                pop;

    always_comb
    begin
        cmd_in.base  = items.element_base;
        cmd_in.state = items.element_state;
        case (items.action)
            ACT_LIST_A: cmd_in.kind = CMD_ELEM_A;
            ACT_LIST_B: cmd_in.kind = CMD_ELEM_B;
            ACT_FINISH: cmd_in.kind = CMD_FINISH;
            default:    cmd_in.kind = CMD_NOP;
        endcase
    end

    assign items.ready = (count_reg != CQ_CNT_W'(CQ_DEPTH));
    assign push        = items.valid && items.ready;
    assign cmd_valid   = (count_reg != '0);
    assign pop         = cmd_pop && cmd_valid;
    assign cmd         = cq_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cq_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* hw/rtl/sbsi_back.sv */
// Back end: pending-element queue, merge compare and result register.
`timescale 1ns / 1ps
module sbsi_back import sbsi_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output logic         cmd_pop,
    sbsi_out_if.source   results
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CMP  = 2'b10
    } state_t;

    logic [BASE_W-1:0]  pend_base_mem  [QUEUE_DEPTH];
    logic [STATE_W-1:0] pend_state_mem [QUEUE_DEPTH];
    logic [BASE_W-1:0]  rd_base_reg;
    logic [STATE_W-1:0] rd_state_reg;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               list_b_reg, list_b_next;
    logic [COUNT_W-1:0] matches_reg, matches_next;
    logic               ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_done_reg, out_done_next;
    logic [BASE_W-1:0]  out_base_reg, out_base_next;
    logic [STATE_W-1:0] out_state_reg, out_state_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               out_free;
    logic               is_b;
    logic               mem_we;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_inc;
    logic [STATE_W-1:0] both;

    assign out_free = !out_valid_reg || results.ready;
    assign is_b     = (cmd.kind == CMD_ELEM_B);
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign both     = rd_state_reg & cmd.state;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        list_b_next    = list_b_reg;
        matches_next   = matches_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_done_next  = out_done_reg;
        out_base_next  = out_base_reg;
        out_state_next = out_state_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_FINISH:
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_done_next  = 1'b1;
                                out_base_next  = '0;
                                out_state_next = '0;
                                out_count_next = matches_reg;
                                out_ovf_next   = ovf_reg;
                                head_next      = '0;
                                tail_next      = '0;
                                fill_next      = '0;
                                list_b_next    = 1'b0;
                                matches_next   = '0;
                                ovf_next       = 1'b0;
                                cmd_pop        = 1'b1;
                            end
                        end
                        CMD_ELEM_A, CMD_ELEM_B:
                        begin
                            if (fill_reg != '0 && is_b != list_b_reg)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_CMP;
                            end
                            else if (fill_reg == '0)
                            begin
                                list_b_next = is_b;
                                mem_we      = 1'b1;
                                tail_next   = tail_inc;
                                fill_next   = fill_reg + 1'b1;
                                cmd_pop     = 1'b1;
                            end
                            else if (fill_reg == FILL_W'(QUEUE_DEPTH))
                            begin
                                ovf_next = 1'b1;
                                cmd_pop  = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = tail_inc;
                                fill_next = fill_reg + 1'b1;
                                cmd_pop   = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if (rd_base_reg < cmd.base)
                begin
                    head_next = head_inc;
                    if (fill_reg == FILL_W'(1))
                    begin
                        // queue drained: the arriving element takes over
                        list_b_next = is_b;
                        mem_we      = 1'b1;
                        tail_next   = tail_inc;
                        cmd_pop     = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        fill_next = fill_reg - 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = head_inc;
                    end
                end
                else if (rd_base_reg == cmd.base)
                begin
                    if (both == '0)
                    begin
                        head_next  = head_inc;
                        fill_next  = fill_reg - 1'b1;
                        cmd_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        head_next      = head_inc;
                        fill_next      = fill_reg - 1'b1;
                        matches_next   = (matches_reg == '1) ? matches_reg
                                                             : matches_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_done_next  = 1'b0;
                        out_base_next  = cmd.base;
                        out_state_next = both;
                        out_count_next = matches_next;
                        out_ovf_next   = ovf_reg;
                        cmd_pop        = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            list_b_reg    <= 1'b0;
            matches_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            list_b_reg    <= list_b_next;
            matches_reg   <= matches_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_done_reg  <= out_done_next;
        out_base_reg  <= out_base_next;
        out_state_reg <= out_state_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_base_mem[tail_reg]  <= cmd.base;
            pend_state_mem[tail_reg] <= cmd.state;
        end
        if (rd_en)
        begin
            rd_base_reg  <= pend_base_mem[rd_addr];
            rd_state_reg <= pend_state_mem[rd_addr];
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.is_done       = out_done_reg;
    assign results.result_base   = out_base_reg;
    assign results.result_state  = out_state_reg;
    assign results.match_count   = out_count_reg;
    assign results.overflow_seen = out_ovf_reg;

endmodule

/* hw/rtl/sorted_bitmap_set_intersect.sv */
// Top level of the sorted bitmap set intersect block.
`timescale 1ns / 1ps
// Intersects two base-plus-state lists that arrive interleaved on one item
// channel; a finish item reports the match count and clears the block. A
// four-entry command queue decouples intake from the merge engine, so items
// are taken every cycle until it fills. In the merge engine an element of the
// queued list, or one that finds the queue empty, is written to the pending
// memory unless it is full; an element of the other list reads the queue head
// from the one-read pending memory and then drops each smaller queued element,
// with a single base compare per cycle, until it meets an equal or larger base
// or drains the queue. A held result item stalls matches and finishes until it
// is taken. The pending memory needs no clearing pass after reset.
module sorted_bitmap_set_intersect import sbsi_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbsi_in_if.sink     items,
    sbsi_out_if.source  results
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    sbsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    sbsi_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .results   (results)
    );

endmodule

/* hw/rtl/sbsi_checker.sv */
// Port-level assertions for the sorted bitmap set intersect block, with bind.
`timescale 1ns / 1ps
module sbsi_checker import sbsi_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               out_is_done,
    input logic [BASE_W-1:0]  out_base,
    input logic [STATE_W-1:0] out_state,
    input logic [COUNT_W-1:0] out_count,
    input logic               out_ovf
);

    a_match_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_is_done |-> out_state != '0)
        else $error("match item with zero state");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_is_done |-> out_count != '0)
        else $error("match item with zero count");

    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_is_done |-> out_base == '0 && out_state == '0)
        else $error("finish report carries base or state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_is_done)
            && $stable(out_base) && $stable(out_state) && $stable(out_count)
            && $stable(out_ovf))
        else $error("stalled result item changed");

endmodule

bind sorted_bitmap_set_intersect sbsi_checker u_sbsi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_is_done (results.is_done),
    .out_base    (results.result_base),
    .out_state   (results.result_state),
    .out_count   (results.match_count),
    .out_ovf     (results.overflow_seen)
);
